>>> rtl/p2r_pkg.sv
// Package for the polar-to-rectangular converter: payload word types,
// fixed-point widths, the CORDIC arctangent table and the rounding helpers.
// Depends on nothing; used by rtl/polar_to_rectangular.sv.
package p2r_pkg;

  // Number of CORDIC micro-rotations (8 to 32) and width of the result parts.
  localparam int CORDIC_STAGES = 16;
  localparam int DATA_WIDTH    = 16;

  // Input fields are fixed at 16 bits.
  localparam int IN_WIDTH = 16;

  // Phase units per full turn, and its split into a power of two and an odd factor.
  localparam int TURN_UNITS = 23040;
  localparam int TURN_SHIFT = 9;
  localparam int TURN_DIV   = TURN_UNITS / (2 ** TURN_SHIFT);

  // Binary angle: one turn is 2^ANG_W.
  localparam int ANG_W  = 32;
  localparam int FRAC_W = ANG_W - TURN_SHIFT;
  localparam int PH_W   = $clog2(TURN_UNITS);
  localparam int PHX_W  = IN_WIDTH + 2;
  localparam int QUO_W  = $clog2(TURN_UNITS / TURN_DIV);
  localparam int RIDX_W = $clog2(TURN_DIV);
  localparam int REM_W  = PH_W + 2;

  // Reciprocal of the odd factor, rounded up; the estimate is high by at most one.
  localparam int Q_SHIFT = 16;
  localparam int Q_RECIP = (2 ** Q_SHIFT + TURN_DIV - 1) / TURN_DIV;
  localparam int QP_W    = PH_W + $clog2(Q_RECIP);
  localparam int QEST_W  = QP_W - Q_SHIFT;

  // Binary-angle step for one unit of remainder.
  localparam int REM_STEP = (2 ** FRAC_W) / TURN_DIV;

  // Gain compensation 1/K in Q30 and the guard bits kept below the Q8.8 point.
  localparam int GAIN_Q30   = 652032874;
  localparam int GAIN_W     = 31;
  localparam int GUARD_BITS = 16;
  localparam int PROD_W     = IN_WIDTH + GAIN_W;
  localparam int ACC_WIDTH  = IN_WIDTH + GUARD_BITS + 2;

  // Rounding and saturation widths.
  localparam int RND_W = ACC_WIDTH - GUARD_BITS;
  localparam int CMP_W = ((DATA_WIDTH > RND_W) ? DATA_WIDTH : RND_W) + 1;
  localparam logic signed [CMP_W-1:0] SAT_HI =
    CMP_W'((64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1);
  localparam logic signed [CMP_W-1:0] SAT_LO = -SAT_HI;
  localparam logic [DATA_WIDTH-1:0] OUT_MIN_CODE = {1'b1, {(DATA_WIDTH - 1){1'b0}}};

  // A quarter turn in accumulator format.
  localparam logic signed [ACC_WIDTH-1:0] QTR_TURN = ACC_WIDTH'(1) <<< (ANG_W - 2);

  typedef struct packed {
    logic signed [IN_WIDTH-1:0] magnitude;
    logic signed [IN_WIDTH-1:0] phase_degrees;
  } p2r_in_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] real_part;
    logic signed [DATA_WIDTH-1:0] imag_part;
  } p2r_out_t;

  // atan(2^-i) as a binary angle.
  function automatic logic [ANG_W-1:0] atan_angle(input logic [4:0] idx);
    logic [ANG_W-1:0] ang;
    case (idx)
      5'd0:    ang = 32'h20000000;
      5'd1:    ang = 32'h12E4051E;
      5'd2:    ang = 32'h09FB385B;
      5'd3:    ang = 32'h051111D4;
      5'd4:    ang = 32'h028B0D43;
      5'd5:    ang = 32'h0145D7E1;
      5'd6:    ang = 32'h00A2F61E;
      5'd7:    ang = 32'h00517C55;
      5'd8:    ang = 32'h0028BE53;
      5'd9:    ang = 32'h00145F2F;
      5'd10:   ang = 32'h000A2F98;
      5'd11:   ang = 32'h000517CC;
      5'd12:   ang = 32'h00028BE6;
      5'd13:   ang = 32'h000145F3;
      5'd14:   ang = 32'h0000A2FA;
      5'd15:   ang = 32'h0000517D;
      5'd16:   ang = 32'h000028BE;
      5'd17:   ang = 32'h0000145F;
      5'd18:   ang = 32'h00000A30;
      5'd19:   ang = 32'h00000518;
      5'd20:   ang = 32'h0000028C;
      5'd21:   ang = 32'h00000146;
      5'd22:   ang = 32'h000000A3;
      5'd23:   ang = 32'h00000051;
      5'd24:   ang = 32'h00000029;
      5'd25:   ang = 32'h00000014;
      5'd26:   ang = 32'h0000000A;
      5'd27:   ang = 32'h00000005;
      5'd28:   ang = 32'h00000003;
      5'd29:   ang = 32'h00000001;
      5'd30:   ang = 32'h00000001;
      default: ang = 32'h00000000;
    endcase
    return ang;
  endfunction

  // Low binary-angle bits for a remainder r below TURN_DIV:
  // floor((r * 2^FRAC_W + 22) / 45), which works out to
  // r * REM_STEP + ceil(r / 2) over the whole remainder range.
  function automatic logic [FRAC_W-1:0] rem_angle(input logic [RIDX_W-1:0] r);
    logic [FRAC_W-1:0] base;
    logic [FRAC_W-1:0] bump;
    base = FRAC_W'(r) * FRAC_W'(REM_STEP);
    bump = FRAC_W'(r[RIDX_W-1:1]) + FRAC_W'(r[0]);
    return base + bump;
  endfunction

  // Round half up to Q8.8 and clamp symmetrically.
  function automatic logic [DATA_WIDTH-1:0] round_sat(input logic signed [ACC_WIDTH-1:0] v);
    logic signed [ACC_WIDTH-1:0] biased;
    logic signed [CMP_W-1:0]     rnd;
    logic signed [CMP_W-1:0]     sat;
    biased = v + (ACC_WIDTH'(1) <<< (GUARD_BITS - 1));
    rnd    = CMP_W'(signed'(biased[ACC_WIDTH-1:GUARD_BITS]));
    if (rnd > SAT_HI) begin
      sat = SAT_HI;
    end else if (rnd < SAT_LO) begin
      sat = SAT_LO;
    end else begin
      sat = rnd;
    end
    return sat[DATA_WIDTH-1:0];
  endfunction

endpackage

>>> rtl/polar_to_rectangular.sv
// Polar-to-rectangular converter: phase reduction, gain compensation and an
// unrolled CORDIC rotation pipeline with rounding and saturation.
// Depends on rtl/p2r_pkg.sv.

// The block takes one word per clock cycle: a word is accepted at every rising
// edge where start_i is high, and busy_o is always low because the pipeline
// never stalls. Each result comes out on out_o for exactly one cycle with done_o
// high; the receiver must take it then, as nothing holds it back. The register
// chain is: an input register, two stages that reduce the phase to a binary
// angle and scale the magnitude by 1/K, one stage that folds the angle into the
// right half plane, one register per CORDIC micro-rotation, and the rounding
// and saturation register. Results are Q8.8, rounded half up and clamped to
// plus or minus 2^(DATA_WIDTH-1)-1. There is no state between words and no
// start-up sweep after reset.
module polar_to_rectangular (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  p2r_pkg::p2r_in_t  in_i,
  output logic              done_o,
  output p2r_pkg::p2r_out_t out_o
);

  // Valid bits, one per pipeline stage.
  logic s1_vld_q;
  logic s2_vld_q;
  logic s3_vld_q;
  logic cv_q [p2r_pkg::CORDIC_STAGES+1];
  logic done_q;

  // Stage 1: input register.
  p2r_pkg::p2r_in_t s1_q;

  // Stage 2: reduced phase, quotient estimate and the scaled magnitude product.
  logic signed [p2r_pkg::PHX_W-1:0]  ph_ext;
  logic signed [p2r_pkg::PHX_W-1:0]  p_ext;
  logic        [p2r_pkg::PH_W-1:0]   p_d, p_q;
  logic        [p2r_pkg::QP_W-1:0]   qp_d;
  logic        [p2r_pkg::QEST_W-1:0] qest_d, qest_q;
  logic signed [p2r_pkg::PROD_W-1:0] prod_d, prod_q;

  // Stage 3: exact quotient and remainder, start value of x.
  logic [p2r_pkg::REM_W-1:0]   rem_full;
  logic [p2r_pkg::REM_W-1:0]   rem_fix;
  logic [p2r_pkg::QEST_W-1:0]  qdec;
  logic [p2r_pkg::QUO_W-1:0]   quo_d, quo_q;
  logic [p2r_pkg::RIDX_W-1:0]  rem_d, rem_q;
  logic signed [p2r_pkg::ACC_WIDTH-1:0] x0_d, x0_q;

  // Stage 4 and the CORDIC stages.
  logic [p2r_pkg::ANG_W-1:0] ang;
  logic [p2r_pkg::ANG_W-1:0] zang;
  logic                      flip;
  logic signed [p2r_pkg::ACC_WIDTH-1:0] x_d [p2r_pkg::CORDIC_STAGES+1];
  logic signed [p2r_pkg::ACC_WIDTH-1:0] y_d [p2r_pkg::CORDIC_STAGES+1];
  logic signed [p2r_pkg::ACC_WIDTH-1:0] z_d [p2r_pkg::CORDIC_STAGES+1];
  logic signed [p2r_pkg::ACC_WIDTH-1:0] x_q [p2r_pkg::CORDIC_STAGES+1];
  logic signed [p2r_pkg::ACC_WIDTH-1:0] y_q [p2r_pkg::CORDIC_STAGES+1];
  logic signed [p2r_pkg::ACC_WIDTH-1:0] z_q [p2r_pkg::CORDIC_STAGES+1];

  // Output register.
  p2r_pkg::p2r_out_t out_d, out_q;

  // The pipeline advances every cycle, so the block never refuses a word.
  assign busy_o = 1'b0;

  // Stage 2: the phase is within two turns of zero, so the reduction into one
  // turn is a choice among four offsets. The quotient by 45 is estimated with a
  // reciprocal multiply and corrected in the next stage.
  always_comb begin
    ph_ext = p2r_pkg::PHX_W'(s1_q.phase_degrees);
    if (ph_ext >= p2r_pkg::PHX_W'(p2r_pkg::TURN_UNITS)) begin
      p_ext = ph_ext - p2r_pkg::PHX_W'(p2r_pkg::TURN_UNITS);
    end else if (ph_ext >= 0) begin
      p_ext = ph_ext;
    end else if (ph_ext >= -p2r_pkg::PHX_W'(p2r_pkg::TURN_UNITS)) begin
      p_ext = ph_ext + p2r_pkg::PHX_W'(p2r_pkg::TURN_UNITS);
    end else begin
      p_ext = ph_ext + p2r_pkg::PHX_W'(2 * p2r_pkg::TURN_UNITS);
    end
    p_d    = p_ext[p2r_pkg::PH_W-1:0];
    qp_d   = p2r_pkg::QP_W'(p_d) * p2r_pkg::QP_W'(p2r_pkg::Q_RECIP);
    qest_d = qp_d[p2r_pkg::QP_W-1:p2r_pkg::Q_SHIFT];
    prod_d = p2r_pkg::PROD_W'(signed'(s1_q.magnitude))
           * p2r_pkg::PROD_W'(p2r_pkg::GAIN_Q30);
  end

  // Stage 3: when the estimate overshoots, the remainder goes negative and one
  // step back fixes both quotient and remainder.
  always_comb begin
    rem_full = p2r_pkg::REM_W'(p_q)
             - p2r_pkg::REM_W'(qest_q) * p2r_pkg::REM_W'(p2r_pkg::TURN_DIV);
    rem_fix  = rem_full + p2r_pkg::REM_W'(p2r_pkg::TURN_DIV);
    qdec     = qest_q - 1'b1;
    if (rem_full[p2r_pkg::REM_W-1]) begin
      quo_d = qdec[p2r_pkg::QUO_W-1:0];
      rem_d = rem_fix[p2r_pkg::RIDX_W-1:0];
    end else begin
      quo_d = qest_q[p2r_pkg::QUO_W-1:0];
      rem_d = rem_full[p2r_pkg::RIDX_W-1:0];
    end
    x0_d = p2r_pkg::ACC_WIDTH'(prod_q >>> (30 - p2r_pkg::GUARD_BITS));
  end

  // Stage 4: the quotient gives the high angle bits and the remainder the low
  // ones. Angles in the second and third quadrants are turned by half a turn,
  // which negates the start vector; flipping the top bit subtracts the half turn.
  always_comb begin
    ang  = {quo_q, p2r_pkg::rem_angle(rem_q)};
    flip = ang[p2r_pkg::ANG_W-1] ^ ang[p2r_pkg::ANG_W-2];
    zang = flip ? {~ang[p2r_pkg::ANG_W-1], ang[p2r_pkg::ANG_W-2:0]} : ang;
    z_d[0] = p2r_pkg::ACC_WIDTH'(signed'(zang));
    x_d[0] = flip ? -x0_q : x0_q;
    y_d[0] = '0;
  end

  // One micro-rotation per stage; a residual angle of zero rotates positively.
  for (genvar i = 0; i < p2r_pkg::CORDIC_STAGES; i++) begin : g_rot
    logic signed [p2r_pkg::ACC_WIDTH-1:0] dx;
    logic signed [p2r_pkg::ACC_WIDTH-1:0] dy;
    logic signed [p2r_pkg::ACC_WIDTH-1:0] da;

    always_comb begin
      dx = y_q[i] >>> i;
      dy = x_q[i] >>> i;
      da = p2r_pkg::ACC_WIDTH'(p2r_pkg::atan_angle(5'(i)));
      if (!z_q[i][p2r_pkg::ACC_WIDTH-1]) begin
        x_d[i+1] = x_q[i] - dx;
        y_d[i+1] = y_q[i] + dy;
        z_d[i+1] = z_q[i] - da;
      end else begin
        x_d[i+1] = x_q[i] + dx;
        y_d[i+1] = y_q[i] - dy;
        z_d[i+1] = z_q[i] + da;
      end
    end

    always_ff @(posedge clk_i) begin
      x_q[i+1] <= x_d[i+1];
      y_q[i+1] <= y_d[i+1];
      z_q[i+1] <= z_d[i+1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cv_q[i+1] <= 1'b0;
      end else begin
        cv_q[i+1] <= cv_q[i];
      end
    end
  end

  // Final rounding to Q8.8 with symmetric saturation.
  always_comb begin
    out_d.real_part = p2r_pkg::round_sat(x_q[p2r_pkg::CORDIC_STAGES]);
    out_d.imag_part = p2r_pkg::round_sat(y_q[p2r_pkg::CORDIC_STAGES]);
  end

  // Valid chain.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      cv_q[0]  <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      s1_vld_q <= start_i & ~busy_o;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      cv_q[0]  <= s3_vld_q;
      done_q   <= cv_q[p2r_pkg::CORDIC_STAGES];
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    s1_q   <= in_i;
    p_q    <= p_d;
    qest_q <= qest_d;
    prod_q <= prod_d;
    quo_q  <= quo_d;
    rem_q  <= rem_d;
    x0_q   <= x0_d;
    x_q[0] <= x_d[0];
    y_q[0] <= y_d[0];
    z_q[0] <= z_d[0];
    out_q  <= out_d;
  end

  assign done_o = done_q;
  assign out_o  = out_q;

`ifndef SYNTHESIS
  a_phase_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_vld_q |-> (p_q < p2r_pkg::PH_W'(p2r_pkg::TURN_UNITS)))
    else $error("reduced phase is not within one turn");

  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_vld_q |-> (rem_q < p2r_pkg::RIDX_W'(p2r_pkg::TURN_DIV)))
    else $error("corrected remainder is out of range");

  a_angle_folded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cv_q[0] |-> ((z_q[0] >= -p2r_pkg::QTR_TURN) && (z_q[0] <= p2r_pkg::QTR_TURN)))
    else $error("start angle is outside a quarter turn");

  a_sat_symmetric: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ((out_o.real_part != p2r_pkg::OUT_MIN_CODE)
             && (out_o.imag_part != p2r_pkg::OUT_MIN_CODE)))
    else $error("result hit the most negative code");
`endif

endmodule

>>> test/polar_to_rectangular_test.sv
// Self-checking testbench for the polar-to-rectangular CORDIC converter: a directed
// stimulus table, then random words, scored against typed rows or a bit-exact predictor.
// Depends on rtl/p2r_pkg.sv and rtl/polar_to_rectangular.sv.
module polar_to_rectangular_test;
  timeunit 1ns;
  timeprecision 1ps;

  import p2r_pkg::*;

  // Number of random words after the directed table, and the stretch of random words
  // that is sent back to back with no idle cycles.
  localparam int RANDOM_WORDS    = 926;
  localparam int BURST_FIRST     = 300;
  localparam int BURST_LAST      = 499;
  localparam int MID_RUN_PAUSE   = 600;
  localparam int IDLE_PERCENT    = 34;
  localparam int DRAIN_CYCLES    = CORDIC_STAGES + 12;

  // Quarter turn in phase units, used to aim at the quadrant boundaries.
  localparam int QUARTER_UNITS = TURN_UNITS / 4;

  // Arctangent of 2^-i as a 32-bit binary angle, one full turn being 2^32.
  localparam logic [31:0] ATAN_BAM [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  // One row of the directed table. Where typed is set, the expected parts are the ones
  // written in the row; otherwise the predictor supplies them.
  typedef struct packed {
    logic signed [IN_WIDTH-1:0]   magnitude;
    logic signed [IN_WIDTH-1:0]   phase;
    bit                           typed;
    logic signed [DATA_WIDTH-1:0] real_exp;
    logic signed [DATA_WIDTH-1:0] imag_exp;
  } stim_row_t;

  // Zero magnitude must give an exact zero whatever the phase. The other rows cover the
  // magnitude extremes (including -32768, which lies outside the stated range and must
  // saturate), each quadrant and its boundaries, the half-turn fold, and phases beyond
  // plus or minus 360 degrees that wrap around the circle.
  localparam stim_row_t STIM_TABLE [24] = '{
    '{16'sd0,       16'sd0,       1'b1, 16'sd0, 16'sd0},
    '{16'sd0,       16'sd23040,   1'b1, 16'sd0, 16'sd0},
    '{16'sd0,       16'sh8000,    1'b1, 16'sd0, 16'sd0},
    '{16'sd32767,   16'sd0,       1'b0, 16'sd0, 16'sd0},
    '{16'sd32767,   16'sd5760,    1'b0, 16'sd0, 16'sd0},
    '{16'sd32767,   16'sd11520,   1'b0, 16'sd0, 16'sd0},
    '{16'sd32767,   16'sd17280,   1'b0, 16'sd0, 16'sd0},
    '{16'sd32767,   -16'sd5760,   1'b0, 16'sd0, 16'sd0},
    '{-16'sd32767,  16'sd0,       1'b0, 16'sd0, 16'sd0},
    '{16'sh8000,    16'sd0,       1'b0, 16'sd0, 16'sd0},
    '{16'sh8000,    16'sd2880,    1'b0, 16'sd0, 16'sd0},
    '{16'sd32767,   16'sd2880,    1'b0, 16'sd0, 16'sd0},
    '{16'sd256,     16'sd0,       1'b0, 16'sd0, 16'sd0},
    '{16'sd256,     16'sd23040,   1'b0, 16'sd0, 16'sd0},
    '{16'sd256,     -16'sd23040,  1'b0, 16'sd0, 16'sd0},
    '{16'sd256,     16'sd32767,   1'b0, 16'sd0, 16'sd0},
    '{16'sd256,     16'sh8000,    1'b0, 16'sd0, 16'sd0},
    '{16'sd256,     16'sd5759,    1'b0, 16'sd0, 16'sd0},
    '{16'sd256,     16'sd5761,    1'b0, 16'sd0, 16'sd0},
    '{16'sd256,     16'sd17279,   1'b0, 16'sd0, 16'sd0},
    '{16'sd256,     16'sd17281,   1'b0, 16'sd0, 16'sd0},
    '{16'sd256,     16'sd1,       1'b0, 16'sd0, 16'sd0},
    '{16'sd1,       -16'sd1,      1'b0, 16'sd0, 16'sd0},
    '{-16'sd1,      16'sd0,       1'b0, 16'sd0, 16'sd0}
  };

  logic     clk = 1'b0;
  logic     rst_n;
  logic     start;
  logic     busy;
  p2r_in_t  in_word;
  logic     done;
  p2r_out_t out_word;

  // A typed expectation travels next to the word it belongs to, so the scoreboard can
  // pick it up at the very edge where the word is accepted.
  bit       hold_typed;
  p2r_out_t typed_rect;

  // Expected rectangular results, oldest first, and the running count of mismatches.
  p2r_out_t pending_rect[$];
  int       mismatch_count = 0;

  polar_to_rectangular u_dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .start_i (start),
    .busy_o  (busy),
    .in_i    (in_word),
    .done_o  (done),
    .out_o   (out_word)
  );

  always begin
    #4ns clk = 1'b1;
    #4ns clk = 1'b0;
  end

  // Round a guard-bit accumulator half up to Q8.8 and clamp it symmetrically.
  function automatic logic [DATA_WIDTH-1:0] round_q88(input longint acc);
    longint lim;
    longint r;
    lim = (64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1;
    r   = (acc + 64'sd32768) >>> 16;
    if (r > lim) begin
      r = lim;
    end else if (r < -lim) begin
      r = -lim;
    end
    return DATA_WIDTH'(r);
  endfunction

  // Bit-exact prediction of one conversion. The phase is wrapped into one turn and
  // rounded to a binary angle; angles in the left half plane are brought back by a
  // half turn with the start vector negated, then the micro-rotations run on 64-bit
  // integers with floor shifts.
  function automatic p2r_out_t rotate_polar(input p2r_in_t w);
    longint      mag;
    longint      p;
    longint      x;
    longint      y;
    longint      z;
    longint      dx;
    longint      dy;
    longint      da;
    logic [31:0] ang;
    int          i;
    p2r_out_t    res;
    mag = w.magnitude;
    p   = w.phase_degrees;
    p   = p % TURN_UNITS;
    if (p < 0) begin
      p = p + TURN_UNITS;
    end
    ang = 32'(((p <<< 32) + (TURN_UNITS / 2)) / TURN_UNITS);
    // Scale by 1/K in Q30, keeping 16 guard bits below the Q8.8 point.
    x = (mag * 64'sd652032874) >>> 14;
    case (ang[31:30])
      2'd0: begin
        z = {32'd0, ang};
      end
      2'd3: begin
        z = {32'd0, ang} - (64'sd1 <<< 32);
      end
      default: begin
        z = {32'd0, ang} - (64'sd1 <<< 31);
        x = -x;
      end
    endcase
    y = 0;
    for (i = 0; i < CORDIC_STAGES && i < 32; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      da = {32'd0, ATAN_BAM[i]};
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - da;
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + da;
      end
    end
    res.real_part = round_q88(x);
    res.imag_part = round_q88(y);
    return res;
  endfunction

  // Scoreboard. Everything is sampled at the rising edge, before the block or the
  // driver update anything, so a result is checked first and then a newly accepted
  // word queues its own expectation.
  always @(posedge clk) begin
    p2r_out_t want;
    if (done) begin
      if (pending_rect.size() == 0) begin
        $display("%0t ns: unexpected result real_part %0d imag_part %0d", $time,
                 out_word.real_part, out_word.imag_part);
        mismatch_count++;
      end else begin
        want = pending_rect.pop_front();
        if (out_word.real_part !== want.real_part) begin
          $display("%0t ns: real_part expected %0d, got %0d", $time,
                   want.real_part, out_word.real_part);
          mismatch_count++;
        end
        if (out_word.imag_part !== want.imag_part) begin
          $display("%0t ns: imag_part expected %0d, got %0d", $time,
                   want.imag_part, out_word.imag_part);
          mismatch_count++;
        end
      end
    end
    if (rst_n && start && !busy) begin
      pending_rect.push_back(hold_typed ? typed_rect : rotate_polar(in_word));
    end
  end

  // Present one word and hold it until the block takes it. On return the clock edge
  // that accepted the word has just passed.
  task automatic send_word(input p2r_in_t w, input bit typed, input p2r_out_t t);
    start      <= 1'b1;
    in_word    <= w;
    hold_typed <= typed;
    typed_rect <= t;
    do begin
      @(posedge clk);
    end while (busy);
  endtask

  // Random idle cycles between words, about a third of all cycles when allowed.
  task automatic maybe_idle(input bit allow);
    while (allow && $urandom_range(99) < IDLE_PERCENT) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Stop sending and let the pipeline empty. The queue is looked at on falling edges,
  // clear of the scoreboard, and driving resumes on the next rising edge.
  task automatic drain_results();
    start <= 1'b0;
    do begin
      @(negedge clk);
    end while (pending_rect.size() != 0);
    @(posedge clk);
  endtask

  // Random word. Most words are fully random so every input bit toggles; the rest aim
  // at in-range phases with small magnitudes, at quadrant boundaries, and at the
  // magnitude extremes.
  function automatic p2r_in_t random_word();
    p2r_in_t w;
    int      mode;
    int      quad;
    mode = $urandom_range(9);
    w.magnitude     = 16'($urandom);
    w.phase_degrees = 16'($urandom);
    if (mode == 6 || mode == 7) begin
      w.phase_degrees = 16'(int'($urandom_range(2 * TURN_UNITS)) - TURN_UNITS);
      w.magnitude     = 16'(int'($urandom_range(2047)) - 1024);
    end else if (mode == 8) begin
      quad = int'($urandom_range(8)) - 4;
      w.phase_degrees = 16'(quad * QUARTER_UNITS + int'($urandom_range(2)) - 1);
    end else if (mode == 9) begin
      case ($urandom_range(5))
        0:       w.magnitude = 16'sd32767;
        1:       w.magnitude = -16'sd32767;
        2:       w.magnitude = 16'sh8000;
        3:       w.magnitude = 16'sd1;
        4:       w.magnitude = -16'sd1;
        default: w.magnitude = 16'sd0;
      endcase
    end
    return w;
  endfunction

  initial begin
    p2r_in_t  w;
    p2r_out_t t;
    rst_n      = 1'b0;
    start      = 1'b0;
    in_word    = '0;
    hold_typed = 1'b0;
    typed_rect = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table, with random idling between rows.
    foreach (STIM_TABLE[r]) begin
      maybe_idle(1'b1);
      w.magnitude     = STIM_TABLE[r].magnitude;
      w.phase_degrees = STIM_TABLE[r].phase;
      t.real_part     = STIM_TABLE[r].real_exp;
      t.imag_part     = STIM_TABLE[r].imag_exp;
      send_word(w, STIM_TABLE[r].typed, t);
    end

    // Let every directed result come back before the random part starts.
    drain_results();

    // Random part: a back-to-back stretch in the middle, and one more full drain
    // later on so the pipeline restarts from empty with random gaps around it.
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n == MID_RUN_PAUSE) begin
        drain_results();
      end
      maybe_idle(n < BURST_FIRST || n > BURST_LAST);
      send_word(random_word(), 1'b0, '0);
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog: stops the run with a failure if it has not finished on its own.
  initial begin
    #2ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule

>>> sim.f
rtl/p2r_pkg.sv
rtl/polar_to_rectangular.sv
test/polar_to_rectangular_test.sv
